FILE: rtl/core/vtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vtc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int DIM         = 4;
  localparam int NUM_ENTRIES = DIM * DIM;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int PAIR_W      = PROD_W + 1;
  localparam int SUM_W       = PROD_W + 2;
  localparam int CLIP_W      = 6;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  localparam int OC_LEFT     = 0;
  localparam int OC_RIGHT    = 1;
  localparam int OC_BOTTOM   = 2;
  localparam int OC_TOP      = 3;
  localparam int OC_NEAR     = 4;
  localparam int OC_FAR      = 5;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COORD_WIDTH:0]   coord_ext_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [PAIR_W-1:0]      pair_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic        [IDX_W-1:0]       idx_t;
  typedef logic        [CLIP_W-1:0]      clip_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/vtc_mul_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module vtc_mul_stage import vtc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   adv,
  input  wire logic   in_valid,
  input  wire logic   opcode,
  input  wire idx_t   entry_index,
  input  wire coord_t entry_value,
  input  wire coord_t vtx [DIM],
  input  wire logic   last,
  output prod_t       prod_r [NUM_ENTRIES],
  output ctl_t        ctl_r
);

  coord_t coeff_r [NUM_ENTRIES];
  logic   load_en;

  assign load_en = in_valid && adv && (opcode == OP_LOAD);

  // loads take effect at acceptance, so a later vertex always sees them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        coeff_r[i] <= '0;
      end
    end else if (load_en) begin
      coeff_r[entry_index] <= entry_value;
    end
  end

  // entry k*DIM + r holds column k, row r
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIM; k++) begin
        for (int r = 0; r < DIM; r++) begin
          prod_r[k*DIM + r] <= prod_t'(coeff_r[k*DIM + r]) * prod_t'(vtx[r]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r.valid <= in_valid && (opcode == OP_VERTEX);
      ctl_r.last  <= last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vtc_sum_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module vtc_sum_stage import vtc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  adv,
  input  wire prod_t prod [NUM_ENTRIES],
  input  wire ctl_t  ctl,
  output sum_t       sum_r [DIM],
  output ctl_t       ctl_r
);

  pair_t pair_r [2*DIM];
  ctl_t  pair_ctl_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIM; k++) begin
        for (int h = 0; h < 2; h++) begin
          pair_r[k*2 + h] <= pair_t'(prod[k*DIM + 2*h]) + pair_t'(prod[k*DIM + 2*h + 1]);
        end
        sum_r[k] <= sum_t'(pair_r[k*2]) + sum_t'(pair_r[k*2 + 1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_ctl_r <= '0;
      ctl_r      <= '0;
    end else if (adv) begin
      pair_ctl_r <= ctl;
      ctl_r      <= pair_ctl_r;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vtc_sat_clip.sv
`timescale 1ns / 1ps
`default_nettype none

module vtc_sat_clip import vtc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  wire sum_t sum [DIM],
  input  wire ctl_t ctl,
  output coord_t    coord_r [DIM],
  output clip_t     clip_r,
  output ctl_t      ctl_r
);

  localparam int TOP_W = SUM_W - (FRAC_BITS + COORD_WIDTH - 1);

  coord_t sat_nxt [DIM];
  coord_t sat_r   [DIM];
  ctl_t   sat_ctl_r;
  clip_t  clip_nxt;

  coord_ext_t w_e;
  coord_ext_t nw_e;
  coord_ext_t x_e;
  coord_ext_t y_e;
  coord_ext_t z_e;

  // floor shift is a plain bit select; saturate when the bits above do not agree
  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      if ((sum[k][SUM_W-1 -: TOP_W] == '0) || (sum[k][SUM_W-1 -: TOP_W] == '1)) begin
        sat_nxt[k] = sum[k][FRAC_BITS +: COORD_WIDTH];
      end else if (sum[k][SUM_W-1]) begin
        sat_nxt[k] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
        sat_nxt[k] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
    end
  end

  // one extra bit so negating the most negative w does not wrap
  always_comb begin
    x_e  = coord_ext_t'(sat_r[0]);
    y_e  = coord_ext_t'(sat_r[1]);
    z_e  = coord_ext_t'(sat_r[2]);
    w_e  = coord_ext_t'(sat_r[3]);
    nw_e = -w_e;
    clip_nxt            = '0;
    clip_nxt[OC_LEFT]   = x_e < nw_e;
    clip_nxt[OC_RIGHT]  = x_e > w_e;
    clip_nxt[OC_BOTTOM] = y_e < nw_e;
    clip_nxt[OC_TOP]    = y_e > w_e;
    clip_nxt[OC_NEAR]   = z_e < 0;
    clip_nxt[OC_FAR]    = z_e > w_e;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sat_r   <= sat_nxt;
      coord_r <= sat_r;
      clip_r  <= clip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_ctl_r <= '0;
      ctl_r     <= '0;
    end else if (adv) begin
      sat_ctl_r <= ctl;
      ctl_r     <= sat_ctl_r;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vertex_transform_clip_codes_top.sv
// 4x4 fixed-point vertex transform with clip outcodes.
// input channel: in_valid / in_stall; in_opcode selects a coefficient load
// (in_entry_index = column*4 + row, in_entry_value) or a vertex (in_x..in_w).
// a load takes effect at once for every vertex accepted after it and gives
// no word on the output side. each vertex gives one output word: the four
// transformed, floored and saturated components, out_clip_code and a copy of
// the batch end marker.
// an accepted vertex passes through the product, pair sum, final sum,
// saturate and clip/output registers in order before it shows on out_valid.
// throughput: one word per cycle unless out_stall holds it; there are sixteen
// 32x32 multipliers and dedicated adders, so nothing is shared between items.
// the whole pipeline advances together: while out_valid is high and out_stall
// is high every stage holds and in_stall is raised, nothing is dropped.
// reset (rst_n low, synchronous) clears all valid bits and sets all sixteen
// coefficients to zero.
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_clip_codes_top import vtc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_stall,
  input  wire logic   in_opcode,
  input  wire idx_t   in_entry_index,
  input  wire coord_t in_entry_value,
  input  wire coord_t in_x,
  input  wire coord_t in_y,
  input  wire coord_t in_z,
  input  wire coord_t in_w,
  input  wire logic   in_last_vertex_in,
  output logic        out_valid,
  input  wire logic   out_stall,
  output coord_t      out_x,
  output coord_t      out_y,
  output coord_t      out_z,
  output coord_t      out_w,
  output clip_t       out_clip_code,
  output logic        out_last_vertex_out
);

  logic   adv;
  coord_t vtx      [DIM];
  prod_t  prod     [NUM_ENTRIES];
  sum_t   sum      [DIM];
  coord_t coord    [DIM];
  ctl_t   mul_ctl;
  ctl_t   sum_ctl;
  ctl_t   out_ctl;
  clip_t  clip;

  assign adv      = !(out_ctl.valid && out_stall);
  assign in_stall = !adv;

  assign vtx[0] = in_x;
  assign vtx[1] = in_y;
  assign vtx[2] = in_z;
  assign vtx[3] = in_w;

  vtc_mul_stage u_mul (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_valid),
    .opcode      (in_opcode),
    .entry_index (in_entry_index),
    .entry_value (in_entry_value),
    .vtx         (vtx),
    .last        (in_last_vertex_in),
    .prod_r      (prod),
    .ctl_r       (mul_ctl)
  );

  vtc_sum_stage u_sum (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .prod  (prod),
    .ctl   (mul_ctl),
    .sum_r (sum),
    .ctl_r (sum_ctl)
  );

  vtc_sat_clip u_sat (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .sum     (sum),
    .ctl     (sum_ctl),
    .coord_r (coord),
    .clip_r  (clip),
    .ctl_r   (out_ctl)
  );

  assign out_valid           = out_ctl.valid;
  assign out_last_vertex_out = out_ctl.last;
  assign out_x               = coord[0];
  assign out_y               = coord[1];
  assign out_z               = coord[2];
  assign out_w               = coord[3];
  assign out_clip_code       = clip;

endmodule

`default_nettype wire
